FILE: src/uswc_pkg.sv
package uswc_pkg;

    localparam int MAX_CHUNK_BYTES_DEF = 32;

    localparam int CFG_AW = 1;
    localparam int CFG_DW = 8;

    localparam logic [CFG_AW-1:0] REG_CHUNK_LEN = 1'b0;
    localparam logic [CFG_AW-1:0] REG_CHUNK_CNT = 1'b1;

    localparam logic [CFG_DW-1:0] CHUNK_LEN_RESET = 8'd0;
    localparam logic [CFG_DW-1:0] CHUNK_CNT_RESET = 8'd8;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] CONT_HI    = 8'hC0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_LEN,
        S_BACK,
        S_EMIT,
        S_ADV,
        S_DROP,
        S_SUM
    } t_state;

    typedef struct packed {
        logic append;
        logic idx_zero;
        logic scan_step;
        logic idx_len;
        logic idx_dec;
        logic len_load;
        logic idx_inc;
        logic out_byte;
        logic out_sum;
        logic advance;
        logic drop;
        logic clear_text;
        logic eot_mode;
    } t_cmd;

    typedef struct packed {
        logic fill_gt_lim;
        logic fill_nonzero;
        logic done_lt_cnt;
        logic in_space_skip;
        logic scan_last;
        logic back_go;
        logic emit_last;
        logic drop_go;
        logic out_free;
    } t_stat;

    // utf-8 continuation byte
    function automatic logic is_cont(input logic [7:0] b);
        return (b >= CONT_LO) && (b < CONT_HI);
    endfunction

endpackage

FILE: src/utf8_safe_word_chunker.sv
// channel   | dir | tdata (low bit up)                                  | tuser      | tlast
// s_axis    | in  | text_byte[7:0]                                      | -          | end_of_text
// m_axis    | out | out_byte[7:0] chunk_number[15:8] chunk_end[16]      | is_summary | last_of_run
//           |     | chunks_made[24:17] zeros[31:25]                     |            |
// cfg       | in  | i_cfg_addr 0 chunk_length_limit, 1 chunk_count_limit, i_cfg_wdata
//
// a text byte that makes no cut passes accept, then the limit check
// a cut over window limit L scans the first L bytes for a space, steps back once
// per utf-8 continuation byte, emits each chunk byte as a word and drops leading
// spaces; the single read port of the window ram moves one byte per cycle
// end of text repeats the cut per waiting chunk, then one summary word
// reset is synchronous active low; the window ram is not cleared
// m_axis_tready low stalls emission; input is taken only between items
module utf8_safe_word_chunker #(
    parameter int MAX_CHUNK_BYTES = uswc_pkg::MAX_CHUNK_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [uswc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [uswc_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // text_byte
    input  logic                        s_axis_tlast,  // end_of_text
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,  // out_byte, chunk_number, chunk_end, chunks_made
    output logic                        m_axis_tuser,  // is_summary
    output logic                        m_axis_tlast   // last_of_run
);

    import uswc_pkg::*;

    t_cmd       cmd;
    t_stat      stat;
    logic [7:0] out_byte;
    logic [7:0] out_num;
    logic       out_end;
    logic [7:0] out_made;

    uswc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_eot   (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    uswc_dp #(
        .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_byte   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (out_byte),
        .o_out_num   (out_num),
        .o_out_end   (out_end),
        .o_out_sum   (m_axis_tuser),
        .o_out_made  (out_made),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, out_made, out_end, out_num, out_byte};

`ifndef ASSERT_OFF
    // a waiting word is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_byte || cmd.out_sum) |-> stat.out_free)
        else $error("output word overwritten");

    // nothing is emitted while input is open
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !(cmd.out_byte || cmd.out_sum || cmd.advance))
        else $error("emission while accepting input");

    // window is empty after the end report
    a_sum_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_sum |=> !stat.fill_nonzero)
        else $error("window not cleared after summary");

    // only one source writes the window or the output at a time
    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.append, cmd.out_byte, cmd.out_sum}))
        else $error("conflicting commands");
`endif

endmodule

FILE: src/uswc_ram.sv
module uswc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/uswc_dp.sv
module uswc_dp #(
    parameter int MAX_CHUNK_BYTES = uswc_pkg::MAX_CHUNK_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [uswc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [uswc_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  logic [7:0]                  i_in_byte,
    input  uswc_pkg::t_cmd              i_cmd,
    output uswc_pkg::t_stat             o_stat,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [7:0]                  o_out_byte,
    output logic [7:0]                  o_out_num,
    output logic                        o_out_end,
    output logic                        o_out_sum,
    output logic [7:0]                  o_out_made,
    output logic                        o_out_last
);

    import uswc_pkg::*;

    localparam int FW    = $clog2(MAX_CHUNK_BYTES + 2);
    localparam int AW    = $clog2(MAX_CHUNK_BYTES + 1);
    localparam int DEPTH = 1 << AW;

    localparam logic [FW-1:0] CAP  = FW'(MAX_CHUNK_BYTES + 1);
    localparam logic [FW-1:0] MAXB = FW'(MAX_CHUNK_BYTES);
    localparam logic [7:0]    MAX8 = 8'(MAX_CHUNK_BYTES);

    logic [CFG_DW-1:0] r_len_cfg;
    logic [CFG_DW-1:0] r_cnt_cfg;

    logic [AW-1:0] r_head, n_head;
    logic [FW-1:0] r_fill, n_fill;
    logic [7:0]    r_done, n_done;
    logic [FW-1:0] r_idx, n_idx;
    logic [FW-1:0] r_space, n_space;
    logic [FW-1:0] r_len, n_len;

    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic [7:0]    r_out_num;
    logic          r_out_end;
    logic          r_out_sum;
    logic [7:0]    r_out_made;
    logic          r_out_last;

    logic [FW-1:0] lim;
    logic [FW-1:0] n_win;
    logic [7:0]    done_inc;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // window ring buffer, head is chunk start
    uswc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_win (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_in_byte),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign lim = ((r_len_cfg == '0) || (r_len_cfg > MAX8)) ? MAXB : r_len_cfg[FW-1:0];
    assign n_win    = (r_fill < lim) ? r_fill : lim;
    assign done_inc = r_done + 8'd1;
    assign wr_addr  = r_head + AW'(r_fill);
    // read address follows next index so data lines up with the index register
    assign rd_addr  = n_head + AW'(n_idx);

    always_comb begin
        n_head  = r_head;
        n_fill  = r_fill;
        n_done  = r_done;
        n_idx   = r_idx;
        n_space = r_space;
        n_len   = r_len;
        wr_en   = 1'b0;
        if (i_cmd.append && (r_fill < CAP)) begin
            wr_en  = 1'b1;
            n_fill = r_fill + FW'(1);
        end
        if (i_cmd.idx_zero) begin
            n_idx   = '0;
            n_space = '0;
        end
        if (i_cmd.scan_step) begin
            if (rd_data == CHAR_SPACE) begin
                n_space = r_idx;
            end
            n_idx = r_idx + FW'(1);
        end
        if (i_cmd.idx_len) begin
            // a space at position 0 does not move the cut
            n_idx = ((r_fill > lim) && (r_space != '0)) ? r_space : n_win;
        end
        if (i_cmd.idx_dec) begin
            n_idx = r_idx - FW'(1);
        end
        if (i_cmd.len_load) begin
            n_len = (r_idx == '0) ? FW'(1) : r_idx;
            n_idx = '0;
        end
        if (i_cmd.idx_inc) begin
            n_idx = r_idx + FW'(1);
        end
        if (i_cmd.advance) begin
            n_head = r_head + AW'(r_len);
            n_fill = r_fill - r_len;
            n_done = done_inc;
            n_idx  = '0;
            if (done_inc >= r_cnt_cfg) begin
                n_fill = '0;
            end
        end
        if (i_cmd.drop) begin
            n_head = r_head + AW'(1);
            n_fill = r_fill - FW'(1);
        end
        if (i_cmd.clear_text) begin
            n_fill = '0;
            n_done = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg <= CHUNK_LEN_RESET;
            r_cnt_cfg <= CHUNK_CNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_CHUNK_LEN: r_len_cfg <= i_cfg_wdata;
                REG_CHUNK_CNT: r_cnt_cfg <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
            r_done <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_space <= n_space;
        r_len   <= n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_byte || i_cmd.out_sum) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_byte) begin
            r_out_byte <= rd_data;
            r_out_num  <= r_done;
            r_out_end  <= o_stat.emit_last;
            r_out_sum  <= 1'b0;
            r_out_made <= '0;
            r_out_last <= o_stat.emit_last && !i_cmd.eot_mode;
        end else if (i_cmd.out_sum) begin
            r_out_byte <= '0;
            r_out_num  <= '0;
            r_out_end  <= 1'b0;
            r_out_sum  <= 1'b1;
            r_out_made <= r_done;
            r_out_last <= 1'b1;
        end
    end

    always_comb begin
        o_stat.fill_gt_lim   = r_fill > lim;
        o_stat.fill_nonzero  = r_fill != '0;
        o_stat.done_lt_cnt   = r_done < r_cnt_cfg;
        o_stat.in_space_skip = (r_fill == '0) && (i_in_byte == CHAR_SPACE);
        o_stat.scan_last     = r_idx == (n_win - FW'(1));
        o_stat.back_go       = (r_idx != '0) && (r_idx < r_fill) && is_cont(rd_data);
        o_stat.emit_last     = r_idx == (r_len - FW'(1));
        o_stat.drop_go       = (r_fill != '0) && (rd_data == CHAR_SPACE);
        o_stat.out_free      = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_num   = r_out_num;
    assign o_out_end   = r_out_end;
    assign o_out_sum   = r_out_sum;
    assign o_out_made  = r_out_made;
    assign o_out_last  = r_out_last;

endmodule

FILE: src/uswc_ctrl.sv
module uswc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_eot,
    output logic            o_in_ready,
    input  uswc_pkg::t_stat i_stat,
    output uswc_pkg::t_cmd  o_cmd
);

    import uswc_pkg::*;

    t_state r_state, n_state;
    logic   r_eot, n_eot;
    logic   in_acc;

    assign in_acc     = (r_state == S_IDLE) && i_in_valid;
    assign o_in_ready = r_state == S_IDLE;
    assign n_eot      = in_acc ? i_in_eot : r_eot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_eot   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eot   <= n_eot;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_eot) begin
                        n_state = S_CHECK;
                    end else if (i_stat.done_lt_cnt && !i_stat.in_space_skip) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_eot ? (i_stat.fill_nonzero && i_stat.done_lt_cnt)
                          : i_stat.fill_gt_lim) begin
                    n_state = i_stat.fill_gt_lim ? S_SCAN : S_LEN;
                end else begin
                    n_state = r_eot ? S_SUM : S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                n_state = S_BACK;
            end
            S_BACK: begin
                if (!i_stat.back_go) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free && i_stat.emit_last) begin
                    n_state = S_ADV;
                end
            end
            S_ADV: begin
                n_state = S_DROP;
            end
            S_DROP: begin
                if (!i_stat.drop_go) begin
                    n_state = r_eot ? S_CHECK : S_IDLE;
                end
            end
            S_SUM: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.eot_mode = r_eot;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.append = in_acc && !i_in_eot && i_stat.done_lt_cnt
                               && !i_stat.in_space_skip;
            end
            S_CHECK: begin
                o_cmd.idx_zero = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            S_LEN: begin
                o_cmd.idx_len = 1'b1;
            end
            S_BACK: begin
                o_cmd.idx_dec  = i_stat.back_go;
                o_cmd.len_load = !i_stat.back_go;
            end
            S_EMIT: begin
                o_cmd.out_byte = i_stat.out_free;
                o_cmd.idx_inc  = i_stat.out_free && !i_stat.emit_last;
            end
            S_ADV: begin
                o_cmd.advance = 1'b1;
            end
            S_DROP: begin
                o_cmd.drop = i_stat.drop_go;
            end
            S_SUM: begin
                o_cmd.out_sum    = i_stat.out_free;
                o_cmd.clear_text = i_stat.out_free;
            end
            default: ;
        endcase
    end

endmodule
